// ===== design/attention_row_route_select_assert.svh =====
// Assertion macros for the route selector modules; only arrs_resolve includes them.
`ifndef ATTENTION_ROW_ROUTE_SELECT_ASSERT_SVH
`define ATTENTION_ROW_ROUTE_SELECT_ASSERT_SVH

// Same-cycle implication, checked on clk and disabled while arst_n is low.
`define ARRS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk and disabled while arst_n is low.
`define ARRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/arrs_pkg.sv =====
// Types and constants of the attention row route selector.
`timescale 1ns / 1ps
`default_nettype none
package arrs_pkg;

	localparam int WORD_W = 32;
	localparam int BQ_W   = 11;
	localparam int PROD_W = WORD_W + BQ_W;
	localparam int BASE_W = PROD_W + 1;
	localparam int IDX_W  = 3;
	localparam int DIV_K  = 2;

	localparam logic [IDX_W-1:0] REG_MODE       = 3'd0;
	localparam logic [IDX_W-1:0] REG_SCOPE      = 3'd1;
	localparam logic [IDX_W-1:0] REG_BYPASS     = 3'd2;
	localparam logic [IDX_W-1:0] REG_MIN_KV     = 3'd3;
	localparam logic [IDX_W-1:0] REG_BLOCK_Q    = 3'd4;
	localparam logic [IDX_W-1:0] REG_DENSE_TAIL = 3'd5;

	localparam logic [1:0] MODE_OFF = 2'd0;
	localparam logic [1:0] MODE_REQ = 2'd2;

	localparam logic [3:0] ROLE_PREFILL = 4'd1;
	localparam logic [3:0] ROLE_TEACHER = 4'd2;
	localparam logic [3:0] ROLE_LAST    = 4'd10;

	localparam logic signed [WORD_W-1:0] POS_UNKNOWN = -32'sd1;

	localparam logic [BQ_W-1:0] BLOCK_Q_RESET = 11'd128;

	typedef enum logic [2:0] {
		RT_SPARSE  = 3'd0,
		RT_EXACT   = 3'd1,
		RT_OFF     = 3'd2,
		RT_ROLE    = 3'd3,
		RT_UNSUP   = 3'd4,
		RT_SHORT   = 3'd5,
		RT_TAIL    = 3'd6,
		RT_UNKNOWN = 3'd7
	} route_t;

	typedef struct packed {
		logic                     header_ok;
		logic [3:0]               role;
		logic signed [WORD_W-1:0] row_pos;
		logic                     pf_known;
		logic signed [WORD_W-1:0] pf_start;
		logic signed [WORD_W-1:0] pf_stop;
		logic [WORD_W-1:0]        resident_tokens;
		logic                     backend_ok;
		logic [WORD_W-1:0]        row_idx;
		logic [WORD_W-1:0]        row_total;
	} arrs_in_t;

	typedef struct packed {
		route_t route;
		logic   is_dense;
	} arrs_out_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic              scope_logical;
		logic              gate_bypass;
		logic [WORD_W-1:0] min_kv;
		logic [BQ_W-1:0]   block_q;
		logic [WORD_W-1:0] tail_tiles;
	} arrs_cfg_t;

	typedef struct packed {
		route_t            route;
		logic              pend;
		logic              backend;
		logic              tail_en;
		logic [BASE_W-1:0] base;
		logic [WORD_W-1:0] total;
	} arrs_side_t;

endpackage
`default_nettype wire

// ===== design/arrs_decode.sv =====
// First two pipeline stages: priority checks, tail product and tail base.
`timescale 1ns / 1ps
`default_nettype none
module arrs_decode import arrs_pkg::*; #(
	parameter int BLOCK_Q_MAX = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic              in_valid,
	input  wire arrs_in_t          in_word,
	input  wire arrs_cfg_t         cfg,
	output logic                   valid_s2,
	output logic [WORD_W-1:0]      row_s2,
	output arrs_side_t             side_s2
);

	localparam logic [WORD_W-1:0] BQ_LIMIT = WORD_W'(BLOCK_Q_MAX);

	logic              cfg_bad;
	logic              row_bad;
	route_t            route_n;
	logic              pend_n;
	logic [PROD_W-1:0] prod_n;

	logic              valid_s1;
	route_t            route_s1;
	logic              pend_s1;
	logic              backend_s1;
	logic              tail_nz_s1;
	logic [WORD_W-1:0] row_s1;
	logic [WORD_W-1:0] total_s1;
	logic [PROD_W-1:0] prod_s1;

	assign cfg_bad = (cfg.mode > MODE_REQ) || (cfg.block_q == '0) ||
		(WORD_W'(cfg.block_q) > BQ_LIMIT);

	assign row_bad = !in_word.header_ok || (in_word.role > ROLE_LAST) ||
		(in_word.row_pos[WORD_W-1] && (in_word.row_pos != POS_UNKNOWN)) ||
		(in_word.pf_known && (in_word.pf_start[WORD_W-1] ||
		(in_word.pf_stop < in_word.pf_start)));

	assign prod_n = PROD_W'(cfg.tail_tiles) * PROD_W'(cfg.block_q);

	always_comb begin
		route_n = RT_SPARSE;
		pend_n  = 1'b0;
		if (cfg_bad || (cfg.mode == MODE_OFF)) begin
			route_n = RT_OFF;
		end else if (row_bad) begin
			route_n = RT_UNKNOWN;
		end else if ((in_word.role != ROLE_PREFILL) && (in_word.role != ROLE_TEACHER)) begin
			route_n = RT_ROLE;
		end else if (cfg.scope_logical && !in_word.pf_known) begin
			route_n = RT_UNKNOWN;
		end else if (cfg.gate_bypass) begin
			route_n = in_word.backend_ok ? RT_EXACT : RT_UNSUP;
		end else if (in_word.resident_tokens < cfg.min_kv) begin
			route_n = RT_SHORT;
		end else begin
			pend_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			route_s1   <= route_n;
			pend_s1    <= pend_n;
			backend_s1 <= in_word.backend_ok;
			tail_nz_s1 <= (cfg.tail_tiles != '0);
			row_s1     <= in_word.row_idx;
			total_s1   <= in_word.row_total;
			prod_s1    <= prod_n;

			row_s2          <= row_s1;
			side_s2.route   <= route_s1;
			side_s2.pend    <= pend_s1;
			side_s2.backend <= backend_s1;
			side_s2.tail_en <= tail_nz_s1 && (total_s1 != '0) && (row_s1 < total_s1);
			side_s2.base    <= BASE_W'(prod_s1) + BASE_W'(row_s1);
			side_s2.total   <= total_s1;
		end
	end

endmodule
`default_nettype wire

// ===== design/arrs_rem_pipe.sv =====
// Pipelined restoring remainder of the packed row by block_q.
`timescale 1ns / 1ps
`default_nettype none
module arrs_rem_pipe import arrs_pkg::*; #(
	parameter int DW = 11
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic [DW-1:0]     divisor,
	input  wire logic              valid_in,
	input  wire logic [WORD_W-1:0] num_in,
	input  wire arrs_side_t        side_in,
	output logic                   valid_out,
	output logic [DW-1:0]          rem_out,
	output arrs_side_t             side_out
);

	localparam int STAGES = WORD_W / DIV_K;

	logic              vld_s  [STAGES];
	logic [DW-1:0]     rem_s  [STAGES];
	logic [WORD_W-1:0] num_s  [STAGES];
	arrs_side_t        side_s [STAGES];

	logic [DW-1:0]     rem_n  [STAGES];
	logic [WORD_W-1:0] num_n  [STAGES];

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic              vld_prev;
		logic [DW-1:0]     rem_prev;
		logic [WORD_W-1:0] num_prev;
		arrs_side_t        side_prev;

		if (g == 0) begin : g_first
			assign vld_prev  = valid_in;
			assign rem_prev  = '0;
			assign num_prev  = num_in;
			assign side_prev = side_in;
		end else begin : g_next
			assign vld_prev  = vld_s[g-1];
			assign rem_prev  = rem_s[g-1];
			assign num_prev  = num_s[g-1];
			assign side_prev = side_s[g-1];
		end

		always_comb begin
			logic [DW:0]       t;
			logic [DW-1:0]     r;
			logic [WORD_W-1:0] n;
			r = rem_prev;
			n = num_prev;
			for (int k = 0; k < DIV_K; k++) begin
				t = {r, n[WORD_W-1]};
				n = {n[WORD_W-2:0], 1'b0};
				if (t >= {1'b0, divisor}) begin
					r = DW'(t - {1'b0, divisor});
				end else begin
					r = t[DW-1:0];
				end
			end
			rem_n[g] = r;
			num_n[g] = n;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (adv) begin
				vld_s[g] <= vld_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[g]  <= rem_n[g];
				num_s[g]  <= num_n[g];
				side_s[g] <= side_prev;
			end
		end
	end

	assign valid_out = vld_s[STAGES-1];
	assign rem_out   = rem_s[STAGES-1];
	assign side_out  = side_s[STAGES-1];

endmodule
`default_nettype wire

// ===== design/arrs_resolve.sv =====
// Final tail compare, route select and output register with skid slot.
`timescale 1ns / 1ps
`default_nettype none
`include "attention_row_route_select_assert.svh"
module arrs_resolve import arrs_pkg::*; #(
	parameter int DW = 11
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          valid_in,
	input  wire logic [DW-1:0] rem_in,
	input  wire arrs_side_t    side_in,
	output logic               adv,
	output logic               out_valid,
	input  wire logic          out_ready,
	output arrs_out_t          out_word
);

	logic      in_tail;
	route_t    route_f;
	arrs_out_t word_n;
	logic      push;
	logic      take;

	logic      out_valid_q;
	logic      skid_valid_q;
	arrs_out_t out_q;
	arrs_out_t skid_q;

	assign in_tail = side_in.tail_en &&
		(BASE_W'(side_in.total) <= (side_in.base - BASE_W'(rem_in)));

	always_comb begin
		route_f = side_in.route;
		if (side_in.pend) begin
			if (in_tail) begin
				route_f = RT_TAIL;
			end else if (side_in.backend) begin
				route_f = RT_SPARSE;
			end else begin
				route_f = RT_UNSUP;
			end
		end
		word_n.route    = route_f;
		word_n.is_dense = (route_f >= RT_OFF);
	end

	assign adv  = !skid_valid_q;
	assign push = adv && valid_in;
	assign take = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (!out_valid_q || take) begin
				out_q <= word_n;
			end else begin
				skid_q <= word_n;
			end
		end else if (take && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	`ARRS_ASSERT_IMP(a_skid_behind_out, skid_valid_q, out_valid_q,
		"skid slot holds a word while the output register is empty")
	`ARRS_ASSERT_IMP(a_skid_only_on_stall, $rose(skid_valid_q),
		$past(out_valid_q && !out_ready), "skid slot filled without a stalled output")
	`ARRS_ASSERT_NEXT(a_skid_drains, skid_valid_q && out_ready, !skid_valid_q,
		"skid slot not drained after the output word was taken")
	`ARRS_ASSERT_IMP(a_dense_flag, out_valid_q,
		out_q.is_dense == (out_q.route >= RT_OFF), "dense flag disagrees with route")

endmodule
`default_nettype wire

// ===== design/attention_row_route_select.sv =====
// Top level of the attention row route selector: configuration and pipeline.
//
//  channel   direction  handshake              payload
//  in        input      in_valid / in_ready    in_word (arrs_in_t)
//  out       output     out_valid / out_ready  out_word (arrs_out_t)
//  cfg       input      cfg_we                 cfg_idx, cfg_wdata
//
// One word is accepted per cycle while in_ready is high; on its way to out_word a word
// passes through two decode stages, 16 remainder stages at two quotient bits each,
// and the output register.
// Reset clears the valid bits and loads the register reset values.
// A stalled output parks one word in the skid slot; in_ready then drops and the
// whole pipeline holds until the slot drains.
`timescale 1ns / 1ps
`default_nettype none
module attention_row_route_select import arrs_pkg::*; #(
	parameter int BLOCK_Q_MAX = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire arrs_in_t          in_word,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output arrs_out_t              out_word,
	input  wire logic              cfg_we,
	input  wire logic [IDX_W-1:0]  cfg_idx,
	input  wire logic [WORD_W-1:0] cfg_wdata
);

	localparam int BQ_CLOG = $clog2(BLOCK_Q_MAX + 1);
	localparam int BQ_DW   = (BQ_CLOG > BQ_W) ? BQ_W : BQ_CLOG;

	logic [1:0]        mode_q;
	logic              scope_logical_q;
	logic              gate_bypass_q;
	logic [WORD_W-1:0] min_kv_q;
	logic [BQ_W-1:0]   block_q_q;
	logic [WORD_W-1:0] dense_tail_q;

	arrs_cfg_t         cfg;
	logic              adv;
	logic              dec_valid;
	logic [WORD_W-1:0] dec_row;
	arrs_side_t        dec_side;
	logic              rem_valid;
	logic [BQ_DW-1:0]  rem_val;
	arrs_side_t        rem_side;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= MODE_OFF;
			scope_logical_q <= 1'b1;
			gate_bypass_q   <= 1'b0;
			min_kv_q        <= '0;
			block_q_q       <= BLOCK_Q_RESET;
			dense_tail_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MODE:       mode_q          <= cfg_wdata[1:0];
				REG_SCOPE:      scope_logical_q <= cfg_wdata[0];
				REG_BYPASS:     gate_bypass_q   <= cfg_wdata[0];
				REG_MIN_KV:     min_kv_q        <= cfg_wdata;
				REG_BLOCK_Q:    block_q_q       <= cfg_wdata[BQ_W-1:0];
				REG_DENSE_TAIL: dense_tail_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg.mode          = mode_q;
	assign cfg.scope_logical = scope_logical_q;
	assign cfg.gate_bypass   = gate_bypass_q;
	assign cfg.min_kv        = min_kv_q;
	assign cfg.block_q       = block_q_q;
	assign cfg.tail_tiles    = dense_tail_q;

	assign in_ready = adv;

	arrs_decode #(
		.BLOCK_Q_MAX(BLOCK_Q_MAX)
	) u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid),
		.in_word  (in_word),
		.cfg      (cfg),
		.valid_s2 (dec_valid),
		.row_s2   (dec_row),
		.side_s2  (dec_side)
	);

	arrs_rem_pipe #(
		.DW(BQ_DW)
	) u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.divisor   (block_q_q[BQ_DW-1:0]),
		.valid_in  (dec_valid),
		.num_in    (dec_row),
		.side_in   (dec_side),
		.valid_out (rem_valid),
		.rem_out   (rem_val),
		.side_out  (rem_side)
	);

	arrs_resolve #(
		.DW(BQ_DW)
	) u_resolve (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (rem_valid),
		.rem_in    (rem_val),
		.side_in   (rem_side),
		.adv       (adv),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule
`default_nettype wire

// ===== tb/attention_row_route_select_tb.sv =====
// Self-checking testbench for the attention row route selector.
`timescale 1ns / 1ps
module attention_row_route_select_tb;
	import arrs_pkg::*;

	localparam int BLOCK_Q_MAX = 1024;
	localparam int PIPE_LAT    = 19;
	localparam int ROWS_PER_SETTING = 120;
	localparam int SETTINGS_N  = 12;

	localparam logic [1:0] MODE_AUTO    = 2'd1;
	localparam logic [1:0] MODE_ILLEGAL = 2'd3;

	localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

	class route_scoreboard;
		arrs_cfg_t regs;
		arrs_out_t route_q[$];
		int        errors;
		int        checked;
		int        seen[8];

		function new();
			regs.mode = MODE_OFF;
			regs.scope_logical = 1'b1;
			regs.gate_bypass = 1'b0;
			regs.min_kv = '0;
			regs.block_q = BLOCK_Q_RESET;
			regs.tail_tiles = '0;
			errors = 0;
			checked = 0;
			foreach (seen[i]) seen[i] = 0;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [WORD_W-1:0] val);
			case (idx)
				REG_MODE:       regs.mode = val[1:0];
				REG_SCOPE:      regs.scope_logical = val[0];
				REG_BYPASS:     regs.gate_bypass = val[0];
				REG_MIN_KV:     regs.min_kv = val;
				REG_BLOCK_Q:    regs.block_q = val[BQ_W-1:0];
				REG_DENSE_TAIL: regs.tail_tiles = val;
				default: ;
			endcase
		endfunction

		function bit in_dense_tail(logic [WORD_W-1:0] row, logic [WORD_W-1:0] total);
			longint unsigned bq, tail, tiles, keep;
			bq = regs.block_q;
			tail = regs.tail_tiles;
			if (tail == 0 || total == 0 || bq == 0 || row >= total)
				return 1'b0;
			tiles = (64'(total) + bq - 1) / bq;
			keep = (tail < tiles) ? tail : tiles;
			return (64'(row) / bq) >= (tiles - keep);
		endfunction

		function route_t predict_route(arrs_in_t w);
			if (regs.mode == MODE_ILLEGAL || regs.block_q == '0 || regs.block_q > BLOCK_Q_MAX)
				return RT_OFF;
			if (regs.mode == MODE_OFF)
				return RT_OFF;
			if (!w.header_ok || w.role > ROLE_LAST ||
					(w.row_pos != POS_UNKNOWN && w.row_pos[WORD_W-1]) ||
					(w.pf_known && (w.pf_start[WORD_W-1] ||
					$signed(w.pf_stop) < $signed(w.pf_start))))
				return RT_UNKNOWN;
			if (w.role != ROLE_PREFILL && w.role != ROLE_TEACHER)
				return RT_ROLE;
			if (regs.scope_logical && !w.pf_known)
				return RT_UNKNOWN;
			if (regs.gate_bypass)
				return w.backend_ok ? RT_EXACT : RT_UNSUP;
			if (w.resident_tokens < regs.min_kv)
				return RT_SHORT;
			if (in_dense_tail(w.row_idx, w.row_total))
				return RT_TAIL;
			if (!w.backend_ok)
				return RT_UNSUP;
			return RT_SPARSE;
		endfunction

		function void note_row(arrs_in_t w);
			arrs_out_t want;
			want.route = predict_route(w);
			want.is_dense = (want.route >= RT_OFF);
			route_q.push_back(want);
		endfunction

		function void check_word(arrs_out_t got);
			arrs_out_t want;
			if (route_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected route word: route %0d is_dense %0b",
					$time, got.route, got.is_dense);
				return;
			end
			want = route_q.pop_front();
			checked++;
			seen[int'(want.route)]++;
			if (got.route !== want.route) begin
				errors++;
				$display("%0t: route mismatch: expected %0d actual %0d",
					$time, want.route, got.route);
			end
			if (got.is_dense !== want.is_dense) begin
				errors++;
				$display("%0t: is_dense mismatch: expected %0b actual %0b",
					$time, want.is_dense, got.is_dense);
			end
		endfunction

		function int pending();
			return route_q.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	arrs_in_t          in_word = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	arrs_out_t         out_word;
	logic              cfg_we = 1'b0;
	logic [IDX_W-1:0]  cfg_idx = '0;
	logic [WORD_W-1:0] cfg_wdata = '0;

	route_scoreboard sb;
	int send_idle = 0;
	int recv_idle = 0;
	int sent = 0;
	int settings = 0;

	attention_row_route_select #(
		.BLOCK_Q_MAX(BLOCK_Q_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	task automatic send_row(arrs_in_t r);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= r;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_row(r);
		sent++;
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [WORD_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic apply_cfg(arrs_cfg_t c);
		write_reg(REG_MODE, WORD_W'(c.mode));
		write_reg(REG_SCOPE, WORD_W'(c.scope_logical));
		write_reg(REG_BYPASS, WORD_W'(c.gate_bypass));
		write_reg(REG_MIN_KV, c.min_kv);
		write_reg(REG_BLOCK_Q, WORD_W'(c.block_q));
		write_reg(REG_DENSE_TAIL, c.tail_tiles);
		write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
		cfg_we <= 1'b0;
		settings++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (PIPE_LAT) @(posedge clk);
	endtask

	function automatic arrs_in_t base_row();
		arrs_in_t r;
		r = '0;
		r.header_ok = 1'b1;
		r.role = ROLE_PREFILL;
		r.row_pos = 32'sd5;
		r.pf_known = 1'b1;
		r.pf_start = 32'sd0;
		r.pf_stop = 32'sd10;
		r.resident_tokens = 32'd1000;
		r.backend_ok = 1'b1;
		r.row_idx = 32'd0;
		r.row_total = 32'd1;
		return r;
	endfunction

	function automatic arrs_cfg_t make_cfg(int p);
		arrs_cfg_t c;
		c.mode = ($urandom_range(9) == 0) ? MODE_OFF :
			($urandom_range(1) ? MODE_AUTO : MODE_REQ);
		c.scope_logical = 1'($urandom_range(1));
		c.gate_bypass = ($urandom_range(4) == 0);
		c.min_kv = $urandom_range(1) ? $urandom_range(0, 128) : $urandom;
		c.block_q = ($urandom_range(3) == 0) ? BQ_W'($urandom_range(1, BLOCK_Q_MAX)) :
			BQ_W'($urandom_range(1, 16));
		c.tail_tiles = ($urandom_range(4) == 0) ? $urandom : $urandom_range(0, 4);
		case (p)
			0: c.mode = MODE_ILLEGAL;
			1: c.block_q = '0;
			2: c.block_q = '1;
			3: begin
				c.block_q = BQ_W'(1);
				c.gate_bypass = 1'b0;
			end
			4: begin
				c.block_q = BQ_W'(BLOCK_Q_MAX);
				c.gate_bypass = 1'b0;
			end
			5: c.min_kv = '1;
			6: begin
				c.min_kv = '0;
				c.tail_tiles = '0;
				c.gate_bypass = 1'b0;
			end
			7: c.tail_tiles = '1;
			8: c.mode = MODE_OFF;
			default: ;
		endcase
		return c;
	endfunction

	function automatic arrs_in_t random_row();
		arrs_in_t r;
		logic [WORD_W-1:0] a, b, t;
		if ($urandom_range(99) < 22) begin
			r.header_ok = 1'($urandom_range(1));
			r.role = 4'($urandom_range(15));
			r.row_pos = $urandom;
			r.pf_known = 1'($urandom_range(1));
			r.pf_start = $urandom;
			r.pf_stop = $urandom;
			r.resident_tokens = $urandom;
			r.backend_ok = 1'($urandom_range(1));
			r.row_idx = $urandom;
			r.row_total = $urandom;
			return r;
		end
		r.header_ok = 1'b1;
		r.role = ($urandom_range(9) == 0) ? 4'($urandom_range(ROLE_LAST)) :
			($urandom_range(1) ? ROLE_PREFILL : ROLE_TEACHER);
		r.row_pos = ($urandom_range(3) == 0) ? POS_UNKNOWN : ($urandom & 32'h7fff_ffff);
		r.pf_known = ($urandom_range(7) != 0);
		a = $urandom_range(1) ? $urandom_range(0, 4096) : ($urandom & 32'h7fff_ffff);
		b = $urandom_range(1) ? $urandom_range(0, 4096) : ($urandom & 32'h7fff_ffff);
		if (a > b) begin
			t = a;
			a = b;
			b = t;
		end
		r.pf_start = a;
		r.pf_stop = b;
		case ($urandom_range(3))
			0: r.resident_tokens = $urandom;
			1: r.resident_tokens = $urandom_range(0, 256);
			2: r.resident_tokens = sb.regs.min_kv;
			default: r.resident_tokens = sb.regs.min_kv - 32'd1;
		endcase
		r.backend_ok = ($urandom_range(9) != 0);
		if ($urandom_range(3) == 0) begin
			r.row_total = $urandom;
			r.row_idx = $urandom_range(1) ? $urandom :
				r.row_total - $urandom_range(0, 4096);
		end else begin
			r.row_total = $urandom_range(0, 96);
			r.row_idx = $urandom_range(0, r.row_total + 4);
		end
		return r;
	endfunction

	task automatic run_directed();
		arrs_in_t r;
		arrs_cfg_t c;
		// Reset values: mode off routes everything off.
		r = base_row();
		send_row(r);
		r.header_ok = 1'b0;
		send_row(r);
		drain();
		// Only mode is written, so the other registers keep their reset values.
		write_reg(REG_MODE, WORD_W'(MODE_AUTO));
		cfg_we <= 1'b0;
		r = base_row();
		send_row(r);
		r.pf_known = 1'b0;
		send_row(r);
		drain();

		c = '{mode: MODE_REQ, scope_logical: 1'b0, gate_bypass: 1'b0, min_kv: 32'd100,
			block_q: 11'd4, tail_tiles: 32'd2};
		apply_cfg(c);
		r = base_row(); r.header_ok = 1'b0; send_row(r);
		r = base_row(); r.role = ROLE_LAST + 4'd1; send_row(r);
		r = base_row(); r.role = 4'hf; send_row(r);
		r = base_row(); r.row_pos = -32'sd2; send_row(r);
		r = base_row(); r.row_pos = 32'sh8000_0000; send_row(r);
		r = base_row(); r.row_pos = POS_UNKNOWN; r.pf_known = 1'b0; send_row(r);
		r = base_row(); r.pf_start = -32'sd1; send_row(r);
		r = base_row(); r.pf_start = 32'sd20; r.pf_stop = 32'sd19; send_row(r);
		r = base_row(); r.pf_known = 1'b0; r.pf_start = -32'sd5;
		r.pf_stop = -32'sd9; send_row(r);
		r = base_row(); r.role = 4'd0; send_row(r);
		r = base_row(); r.role = ROLE_LAST; send_row(r);
		r = base_row(); r.role = ROLE_TEACHER; r.resident_tokens = 32'd99; send_row(r);
		r = base_row(); r.resident_tokens = 32'd0; send_row(r);
		r = base_row(); r.resident_tokens = '1; r.row_total = 32'd16;
		r.row_idx = 32'd15; send_row(r);
		r.row_idx = 32'd7; send_row(r);
		r.row_idx = 32'd16; send_row(r);
		r = base_row(); r.row_total = 32'd0; send_row(r);
		r = base_row(); r.backend_ok = 1'b0; send_row(r);
		r = base_row(); r.row_pos = 32'sh7fff_ffff; r.row_idx = '1;
		r.row_total = '1; send_row(r);
		drain();

		c = '{mode: MODE_AUTO, scope_logical: 1'b1, gate_bypass: 1'b1, min_kv: '1,
			block_q: 11'd1024, tail_tiles: '1};
		apply_cfg(c);
		r = base_row(); send_row(r);
		r.backend_ok = 1'b0; send_row(r);
		r = base_row(); r.pf_known = 1'b0; send_row(r);
		drain();
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (out_valid && out_ready)
					sb.check_word(out_word);
				out_ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("attention_row_route_select verification failed");
		$finish;
	end

	initial begin
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle = 12;
		recv_idle = 67;
		run_directed();
		for (int p = 0; p < SETTINGS_N; p++) begin
			if (p < SETTINGS_N / 3) begin
				send_idle = 12;
				recv_idle = 67;
			end else if (p < 2 * SETTINGS_N / 3) begin
				send_idle = 67;
				recv_idle = 12;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			apply_cfg(make_cfg(p));
			repeat (ROWS_PER_SETTING) send_row(random_row());
			drain();
		end
		$display("Checked %0d route words from %0d rows across %0d register settings.",
			sb.checked, sent, settings);
		$display("Routes sp %0d ex %0d off %0d role %0d uns %0d sh %0d tail %0d unk %0d",
			sb.seen[RT_SPARSE], sb.seen[RT_EXACT], sb.seen[RT_OFF], sb.seen[RT_ROLE],
			sb.seen[RT_UNSUP], sb.seen[RT_SHORT], sb.seen[RT_TAIL], sb.seen[RT_UNKNOWN]);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("attention_row_route_select verification clean");
		end else begin
			$display("attention_row_route_select verification failed");
		end
		$finish;
	end
endmodule
